FILE: sv/rcpb_pkg.sv
`default_nettype none
package rcpb_pkg;

  // Result status codes
  localparam logic STATUS_CLIPPED = 1'b0;
  localparam logic STATUS_INSIDE  = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_XMIN = 2'd0,
    REG_XMAX = 2'd1,
    REG_YMIN = 2'd2,
    REG_YMAX = 2'd3
  } cfg_reg_t;

endpackage
`default_nettype wire

FILE: sv/rcpb_div_pipe.sv
`default_nettype none
// Restoring divider, one quotient bit per register stage, dividend < divisor.
module rcpb_div_pipe #(
  parameter int MW = 33,
  parameter int QB = 16
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [MW-1:0] dividend,
  input  wire logic [MW-1:0] divisor,
  output logic      [QB-1:0] quotient
);

  logic [MW-1:0] rem_r [QB];
  logic [MW-1:0] dvs_r [QB];
  logic [QB-1:0] quo_r [QB];
  logic [MW:0]   step_s [QB];

  // One restoring step: shift the remainder, subtract the divisor where it fits
  function automatic logic [MW:0] div_step(logic [MW-1:0] rem, logic [MW-1:0] dvs);
    logic [MW:0] shifted;
    logic [MW:0] trial;
    shifted = {rem, 1'b0};
    trial   = shifted - {1'b0, dvs};
    if (shifted >= {1'b0, dvs}) return {1'b1, trial[MW-1:0]};
    return {1'b0, shifted[MW-1:0]};
  endfunction

  always_comb begin
    step_s[0] = div_step(dividend, divisor);
    for (int i = 1; i < QB; i++) step_s[i] = div_step(rem_r[i-1], dvs_r[i-1]);
  end

  // Advance one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= step_s[0][MW-1:0];
      dvs_r[0] <= divisor;
      quo_r[0] <= {{(QB-1){1'b0}}, step_s[0][MW]};
      for (int i = 1; i < QB; i++) begin
        rem_r[i] <= step_s[i][MW-1:0];
        dvs_r[i] <= dvs_r[i-1];
        quo_r[i] <= {quo_r[i-1][QB-2:0], step_s[i][MW]};
      end
    end
  end

  assign quotient = quo_r[QB-1];

endmodule
`default_nettype wire

FILE: sv/ray_clip_point_to_box.sv
// Stages 0, 1, 2, the dividers, T, M and O lead to the result (default Q16.16).
// Throughput: one transaction per cycle; the two bit-per-stage dividers set the depth.
// The whole pipeline holds while a result waits under out_stall.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default box
// 0..1.0 in x and y.
`default_nettype none
module ray_clip_point_to_box #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [COORD_BITS-1:0]        cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_centre_x,
  input  wire logic signed [COORD_BITS-1:0] in_centre_y,
  input  wire logic signed [COORD_BITS-1:0] in_target_x,
  input  wire logic signed [COORD_BITS-1:0] in_target_y,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COORD_BITS-1:0]      out_clipped_x,
  output logic signed [COORD_BITS-1:0]      out_clipped_y,
  output logic                              out_status
);
  import rcpb_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int MW = COORD_BITS + 1;
  localparam int TW = FRAC_BITS + 1;
  localparam int PW = MW + TW;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] px;
    logic signed [W-1:0] py;
    logic signed [W-1:0] bx;
    logic signed [W-1:0] by;
    logic                outx;
    logic                outy;
    logic                negx;
    logic                negy;
    logic [MW-1:0]       adx;
    logic [MW-1:0]       ady;
    logic                zx;
    logic                ox;
    logic                zy;
    logic                oy;
  } side_t;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Box registers
  logic signed [W-1:0] xmin_r, xmax_r, ymin_r, ymax_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= '0;
      xmax_r <= W'(1) << FRAC_BITS;
      ymin_r <= '0;
      ymax_r <= W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_XMIN: xmin_r <= cfg_wdata;
        REG_XMAX: xmax_r <= cfg_wdata;
        REG_YMIN: ymin_r <= cfg_wdata;
        REG_YMAX: ymax_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // Stage 0: capture the transaction
  logic                v0_r;
  logic signed [W-1:0] cx0_r, cy0_r, px0_r, py0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cx0_r <= in_centre_x;
      cy0_r <= in_centre_y;
      px0_r <= in_target_x;
      py0_r <= in_target_y;
    end
  end

  // Stage 1: bound selection and differences
  logic                gtx, ltx, gty, lty;
  logic signed [W-1:0] bx_nxt, by_nxt;
  assign gtx    = px0_r > xmax_r;
  assign ltx    = px0_r < xmin_r;
  assign gty    = py0_r > ymax_r;
  assign lty    = py0_r < ymin_r;
  assign bx_nxt = gtx ? xmax_r : xmin_r;
  assign by_nxt = gty ? ymax_r : ymin_r;

  logic                 v1_r;
  logic signed [W-1:0]  cx1_r, cy1_r, px1_r, py1_r, bx1_r, by1_r;
  logic                 outx1_r, outy1_r;
  logic signed [MW-1:0] nx1_r, ny1_r, dx1_r, dy1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v0_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cx1_r   <= cx0_r;
      cy1_r   <= cy0_r;
      px1_r   <= px0_r;
      py1_r   <= py0_r;
      bx1_r   <= bx_nxt;
      by1_r   <= by_nxt;
      outx1_r <= gtx || ltx;
      outy1_r <= gty || lty;
      nx1_r   <= MW'(bx_nxt) - MW'(cx0_r);
      ny1_r   <= MW'(by_nxt) - MW'(cy0_r);
      dx1_r   <= MW'(px0_r) - MW'(cx0_r);
      dy1_r   <= MW'(py0_r) - MW'(cy0_r);
    end
  end

  // Stage 2: magnitudes and saturation flags
  logic [MW-1:0] anx, any_m, adx, ady;
  assign anx   = nx1_r[MW-1] ? MW'(-nx1_r) : MW'(nx1_r);
  assign any_m = ny1_r[MW-1] ? MW'(-ny1_r) : MW'(ny1_r);
  assign adx   = dx1_r[MW-1] ? MW'(-dx1_r) : MW'(dx1_r);
  assign ady   = dy1_r[MW-1] ? MW'(-dy1_r) : MW'(dy1_r);

  logic          v2_r;
  side_t         s2_r;
  logic [MW-1:0] anx2_r, any2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_r.cx   <= cx1_r;
      s2_r.cy   <= cy1_r;
      s2_r.px   <= px1_r;
      s2_r.py   <= py1_r;
      s2_r.bx   <= bx1_r;
      s2_r.by   <= by1_r;
      s2_r.outx <= outx1_r;
      s2_r.outy <= outy1_r;
      s2_r.negx <= dx1_r[MW-1];
      s2_r.negy <= dy1_r[MW-1];
      s2_r.adx  <= adx;
      s2_r.ady  <= ady;
      s2_r.zx   <= (adx == '0) || ((nx1_r[MW-1] != dx1_r[MW-1]) && (anx != '0));
      s2_r.zy   <= (ady == '0) || ((ny1_r[MW-1] != dy1_r[MW-1]) && (any_m != '0));
      s2_r.ox   <= anx >= adx;
      s2_r.oy   <= any_m >= ady;
      anx2_r    <= anx;
      any2_r    <= any_m;
    end
  end

  // Dividers: fraction of the ray to each crossed bound
  logic [FRAC_BITS-1:0] qx, qy;
  rcpb_div_pipe #(.MW(MW), .QB(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .dividend(anx2_r), .divisor(s2_r.adx), .quotient(qx)
  );
  rcpb_div_pipe #(.MW(MW), .QB(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .dividend(any2_r), .divisor(s2_r.ady), .quotient(qy)
  );

  // Side band delay matching the dividers
  side_t sd_r [FRAC_BITS];
  logic  vd_r [FRAC_BITS];
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= s2_r;
      for (int i = 1; i < FRAC_BITS; i++) sd_r[i] <= sd_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAC_BITS; i++) vd_r[i] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v2_r;
      for (int i = 1; i < FRAC_BITS; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  // Stage T: saturate and pick the ray parameter for each coordinate
  side_t         sq;
  logic [TW-1:0] tx, ty, tmin, tux_nxt, tuy_nxt;
  assign sq   = sd_r[FRAC_BITS-1];
  assign tx   = sq.zx ? '0 : (sq.ox ? TW'(1) << FRAC_BITS : {1'b0, qx});
  assign ty   = sq.zy ? '0 : (sq.oy ? TW'(1) << FRAC_BITS : {1'b0, qy});
  assign tmin = (tx < ty) ? tx : ty;
  always_comb begin
    tux_nxt = tmin;
    tuy_nxt = tmin;
    if (sq.outx && !sq.outy) begin
      tux_nxt = tx;
      tuy_nxt = tx;
    end else if (sq.outy && !sq.outx) begin
      tux_nxt = ty;
      tuy_nxt = ty;
    end
  end

  logic          vt_r;
  side_t         st_r;
  logic [TW-1:0] tux_r, tuy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vt_r <= 1'b0;
    else if (en) vt_r <= vd_r[FRAC_BITS-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      st_r  <= sq;
      tux_r <= tux_nxt;
      tuy_r <= tuy_nxt;
    end
  end

  // Stage M: scale the deltas
  logic          vm_r;
  side_t         sm_r;
  logic [PW-1:0] px_prod_r, py_prod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (en) vm_r <= vt_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sm_r      <= st_r;
      px_prod_r <= PW'(tux_r) * PW'(st_r.adx);
      py_prod_r <= PW'(tuy_r) * PW'(st_r.ady);
    end
  end

  // Stage O: round half away from zero, add to centre, select result
  logic [PW:0]           rsx, rsy;
  logic [PW-FRAC_BITS:0] qmx, qmy;
  logic [W+1:0]          alx, aly;
  logic signed [W-1:0]   rx_nxt, ry_nxt;
  logic                  st_nxt;
  assign rsx = {1'b0, px_prod_r} + ((PW+1)'(1) << (FRAC_BITS - 1));
  assign rsy = {1'b0, py_prod_r} + ((PW+1)'(1) << (FRAC_BITS - 1));
  assign qmx = rsx[PW:FRAC_BITS];
  assign qmy = rsy[PW:FRAC_BITS];
  assign alx = sm_r.negx ? (W+2)'(sm_r.cx) - (W+2)'(qmx) : (W+2)'(sm_r.cx) + (W+2)'(qmx);
  assign aly = sm_r.negy ? (W+2)'(sm_r.cy) - (W+2)'(qmy) : (W+2)'(sm_r.cy) + (W+2)'(qmy);
  always_comb begin
    rx_nxt = alx[W-1:0];
    ry_nxt = aly[W-1:0];
    st_nxt = STATUS_CLIPPED;
    if (sm_r.outx && !sm_r.outy) begin
      rx_nxt = sm_r.bx;
    end else if (sm_r.outy && !sm_r.outx) begin
      ry_nxt = sm_r.by;
    end else if (!sm_r.outx && !sm_r.outy) begin
      rx_nxt = sm_r.px;
      ry_nxt = sm_r.py;
      st_nxt = STATUS_INSIDE;
    end
  end

  logic                ov_r;
  logic signed [W-1:0] ox_r, oy_r;
  logic                os_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= vm_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ox_r <= rx_nxt;
      oy_r <= ry_nxt;
      os_r <= st_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_clipped_x = ox_r;
  assign out_clipped_y = oy_r;
  assign out_status    = os_r;

endmodule
`default_nettype wire

FILE: sv/rcpb_checker.sv
`default_nettype none
module rcpb_checker #(
  parameter int COORD_BITS = 32
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [COORD_BITS-1:0] out_clipped_x,
  input wire logic [COORD_BITS-1:0] out_clipped_y,
  input wire logic                  out_status
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_clipped_x)
      && $stable(out_clipped_y) && $stable(out_status))
    else $error("stalled result changed");

  // Input back-pressure only from a stalled result
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without output stall");

  // Reset empties the pipeline
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  // A valid result carries known data
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_clipped_x, out_clipped_y, out_status}))
    else $error("unknown result data");

endmodule

bind ray_clip_point_to_box rcpb_checker #(.COORD_BITS(COORD_BITS)) u_rcpb_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_clipped_x(out_clipped_x),
  .out_clipped_y(out_clipped_y), .out_status(out_status)
);
`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none
module tb;
  import rcpb_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LATENCY = FB + 6;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t px;
    coord_t py;
  } point_pair_t;

  typedef struct packed {
    coord_t rx;
    coord_t ry;
    logic   st;
  } clip_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_XMIN;
  coord_t cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_centre_x = '0, in_centre_y = '0, in_target_x = '0, in_target_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_clipped_x, out_clipped_y;
  logic out_status;

  ray_clip_point_to_box #(.COORD_BITS(CW), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_centre_x(in_centre_x), .in_centre_y(in_centre_y),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_clipped_x(out_clipped_x), .out_clipped_y(out_clipped_y),
    .out_status(out_status)
  );

  // Box as the predictor sees it
  coord_t bx_lo = 0, bx_hi = 65536, by_lo = 0, by_hi = 65536;

  point_pair_t pending_points[$];
  clip_res_t   expected_clips[$];
  int errors = 0;
  bit quiet = 0;      // no idling in the final stretch
  bit hold_out = 0;   // long receiver hold-off request
  int accepted = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("tb failed");
    $finish;
  end

  // Saturated ray parameter num/den in 0..1.0
  function automatic longint ray_frac(longint num, longint den);
    longint an, ad;
    if (den == 0) return 0;
    if ((num < 0) != (den < 0) && num != 0) return 0;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    if (an >= ad) return longint'(1) << FB;
    return (an << FB) / ad;
  endfunction

  // Step from the centre by t*den, rounding half away from zero
  function automatic longint step_along(longint c, longint t, longint den);
    longint ad, q;
    ad = den < 0 ? -den : den;
    q = (t * ad + (longint'(1) << (FB - 1))) >>> FB;
    return den < 0 ? c - q : c + q;
  endfunction

  function automatic clip_res_t clip_point(point_pair_t p);
    longint cx, cy, px, py, dx, dy, bx, by, tx, ty, t, rx, ry;
    bit ox, oy;
    clip_res_t r;
    cx = p.cx; cy = p.cy; px = p.px; py = p.py;
    dx = px - cx; dy = py - cy;
    rx = px; ry = py; bx = 0; by = 0;
    ox = 1; oy = 1;
    r.st = STATUS_CLIPPED;
    if (px > longint'(bx_hi)) bx = bx_hi;
    else if (px < longint'(bx_lo)) bx = bx_lo;
    else ox = 0;
    if (py > longint'(by_hi)) by = by_hi;
    else if (py < longint'(by_lo)) by = by_lo;
    else oy = 0;
    if (ox && oy) begin
      tx = ray_frac(bx - cx, dx);
      ty = ray_frac(by - cy, dy);
      t = tx < ty ? tx : ty;
      rx = step_along(cx, t, dx);
      ry = step_along(cy, t, dy);
    end else if (ox) begin
      rx = bx;
      ry = step_along(cy, ray_frac(bx - cx, dx), dy);
    end else if (oy) begin
      rx = step_along(cx, ray_frac(by - cy, dy), dx);
      ry = by;
    end else begin
      r.st = STATUS_INSIDE;
    end
    r.rx = rx[CW-1:0];
    r.ry = ry[CW-1:0];
    return r;
  endfunction

  // Driver: offer queued points, with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_clips = {expected_clips, clip_point({in_centre_x, in_centre_y,
                                                      in_target_x, in_target_y})};
        accepted <= accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(1, 15) - 1;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          point_pair_t p;
          p = pending_points.pop_front();
          in_valid <= 1'b1;
          in_centre_x <= p.cx; in_centre_y <= p.cy;
          in_target_x <= p.px; in_target_y <= p.py;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results and drive receiver stall
  int out_gap = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_clips.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h st=%b", $time,
                   out_clipped_x, out_clipped_y, out_status);
          errors++;
        end else begin
          clip_res_t e;
          e = expected_clips.pop_front();
          if (e.rx !== out_clipped_x) begin
            $display("%0t: clipped_x expected %h actual %h", $time, e.rx, out_clipped_x);
            errors++;
          end
          if (e.ry !== out_clipped_y) begin
            $display("%0t: clipped_y expected %h actual %h", $time, e.ry, out_clipped_y);
            errors++;
          end
          if (e.st !== out_status) begin
            $display("%0t: status expected %b actual %b", $time, e.st, out_status);
            errors++;
          end
        end
      end
      // hold off for a long stretch so the pipeline backs up
      if (hold_out && hold_cnt < 200) begin
        hold_cnt <= hold_cnt + 1;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return coord_t'($urandom_range(0, 131072)) - 32768;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return coord_t'($urandom_range(0, 4)) - 2;
      default: return coord_t'($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  task automatic add_point(coord_t cx, coord_t cy, coord_t px, coord_t py);
    point_pair_t p;
    p.cx = cx; p.cy = cy; p.px = px; p.py = py;
    pending_points = {pending_points, p};
  endtask

  task automatic write_box(cfg_reg_t idx, coord_t v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_XMIN: bx_lo = v;
      REG_XMAX: bx_hi = v;
      REG_YMIN: by_lo = v;
      default:  by_hi = v;
    endcase
  endtask

  // Let everything queued drain before touching the box
  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_clips.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_points(int n);
    repeat (n) begin
      coord_t cx, cy;
      if ($urandom_range(0, 3) != 0) begin
        // centre inside the box unless the box is inverted, target anywhere
        cx = bx_lo + coord_t'(($urandom % 2048) * (longint'(bx_hi) - bx_lo) / 2048);
        cy = by_lo + coord_t'(($urandom % 2048) * (longint'(by_hi) - by_lo) / 2048);
        if (bx_hi < bx_lo) cx = rand_coord();
        if (by_hi < by_lo) cy = rand_coord();
      end else begin
        cx = rand_coord();
        cy = rand_coord();
      end
      add_point(cx, cy, rand_coord(), rand_coord());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: default box
    add_point(32768, 32768, 32768, 32768);            // inside
    add_point(32768, 32768, 131072, 32768);           // outside in x only
    add_point(32768, 32768, 32768, -65536);           // outside in y only
    add_point(32768, 32768, 131072, 196608);          // outside in both
    add_point(32768, 32768, -131072, -100000);        // both, low bounds
    add_point(131072, 32768, 131072, 32768);          // zero delta, outside
    add_point(200000, 32768, 300000, 32768);          // ray away from bound
    add_point(0, 0, 65536, 65536);                    // corner exactly
    add_point(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    add_point(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    add_point(0, 0, 32'sh7fffffff, 1);
    add_point(-1, -1, 65537, -65537);
    add_point(32767, 1, 65539, 3);                    // rounding half
    drain();
    // Inverted box
    write_box(REG_XMIN, 65536);
    write_box(REG_XMAX, 0);
    write_box(REG_YMIN, 65536);
    write_box(REG_YMAX, 0);
    add_point(32768, 32768, 32768, 32768);
    add_point(-5, 70000, 100000, -3);
    random_points(100);
    drain();
    // Full-range box
    write_box(REG_XMIN, 32'sh80000000);
    write_box(REG_XMAX, 32'sh7fffffff);
    write_box(REG_YMIN, 32'sh80000000);
    write_box(REG_YMAX, 32'sh7fffffff);
    add_point(0, 0, 32'sh7fffffff, 32'sh80000000);
    random_points(50);
    drain();
    // Wide random boxes, with a long receiver hold-off in the first
    for (int ph = 0; ph < 4; ph++) begin
      coord_t a, b;
      a = rand_coord(); b = rand_coord();
      write_box(REG_XMIN, a < b ? a : b);
      write_box(REG_XMAX, a < b ? b : a);
      a = rand_coord(); b = rand_coord();
      write_box(REG_YMIN, a < b ? a : b);
      write_box(REG_YMAX, a < b ? b : a);
      if (ph == 0) hold_out = 1;
      random_points(250);
      drain();
      hold_out = 0;
    end
    // Back to a small box, no idling in the last batch
    write_box(REG_XMIN, -65536);
    write_box(REG_XMAX, 65536);
    write_box(REG_YMIN, -32768);
    write_box(REG_YMAX, 98304);
    random_points(150);
    quiet = 1;
    random_points(200);
    drain();
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
sv/rcpb_pkg.sv
sv/rcpb_div_pipe.sv
sv/ray_clip_point_to_box.sv
sv/rcpb_checker.sv
tb/sv/tb.sv
